// ===== rtl/core/um32_register_execute_unit_assert.svh =====
// Assertion macros for the UM32 execute unit checker.
`ifndef UM32_REGISTER_EXECUTE_UNIT_ASSERT_SVH
`define UM32_REGISTER_EXECUTE_UNIT_ASSERT_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define UM32_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the same cycle.
`define UM32_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/um32_pkg.sv =====
// Shared types, opcodes and status codes for the UM32 execute unit.
package um32_pkg;
    localparam int RegCount = 8;

    localparam logic [3:0] OP_CMOV  = 4'd0;
    localparam logic [3:0] OP_SLOAD = 4'd1;
    localparam logic [3:0] OP_SSTOR = 4'd2;
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_MUL   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_NAND  = 4'd6;
    localparam logic [3:0] OP_HALT  = 4'd7;
    localparam logic [3:0] OP_MAP   = 4'd8;
    localparam logic [3:0] OP_UNMAP = 4'd9;
    localparam logic [3:0] OP_OUT   = 4'd10;
    localparam logic [3:0] OP_IN    = 4'd11;
    localparam logic [3:0] OP_LDPRG = 4'd12;
    localparam logic [3:0] OP_LDV   = 4'd13;

    localparam logic [2:0] ST_DONE  = 3'd0;
    localparam logic [2:0] ST_EMIT  = 3'd1;
    localparam logic [2:0] ST_HALT  = 3'd2;
    localparam logic [2:0] ST_FAULT = 3'd3;
    localparam logic [2:0] ST_UNSUP = 3'd4;

    typedef struct packed {
        logic [31:0] instruction;
        logic [7:0]  input_byte;
        logic        input_eof;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_byte;
        logic [31:0] written_value;
    } out_item_t;

    // Instruction as held in the queue between front and back.
    typedef struct packed {
        logic [3:0]  op;
        logic [2:0]  ra;
        logic [2:0]  rb;
        logic [2:0]  rc;
        logic [2:0]  rl;
        logic [24:0] imm;
        logic [7:0]  byte_in;
        logic        eof;
    } uop_t;
endpackage

// ===== rtl/core/um32_front.sv =====
// Front end: decode incoming instructions into a two-entry queue.
module um32_front (
    input  logic               clk,
    input  logic               rst_n,
    input  um32_pkg::in_item_t in_item,
    input  logic               in_valid,
    output logic               in_ready,
    output um32_pkg::uop_t     uop,
    output logic               uop_valid,
    input  logic               uop_ready
);
    um32_pkg::uop_t q_reg [2];
    logic           rd_ptr_reg, rd_ptr_next;
    logic           wr_ptr_reg, wr_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    um32_pkg::uop_t dec;
    logic           push, pop;

    always_comb
    begin
        dec.op      = in_item.instruction[31:28];
        dec.ra      = in_item.instruction[8:6];
        dec.rb      = in_item.instruction[5:3];
        dec.rc      = in_item.instruction[2:0];
        dec.rl      = in_item.instruction[27:25];
        dec.imm     = in_item.instruction[24:0];
        dec.byte_in = in_item.input_byte;
        dec.eof     = in_item.input_eof;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign uop_valid = (cnt_reg != 2'd0);
    assign uop       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = uop_valid && uop_ready;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule

// ===== rtl/core/um32_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module um32_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    assign trial    = {r_reg, q_reg[31]} - {1'b0, d_reg};
    assign quotient = q_reg;
    assign done     = busy_reg && (cnt_reg == 6'd32);

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg && cnt_reg != 6'd32)
        begin
            // shift in next dividend bit, subtract if it fits
            if (!trial[32])
            begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end
endmodule

// ===== rtl/core/um32_back.sv =====
// Back end: register file, execution sequencer and output register.
module um32_back #(
    parameter int REGISTER_COUNT = um32_pkg::RegCount
) (
    input  logic                clk,
    input  logic                rst_n,
    input  um32_pkg::uop_t      uop,
    input  logic                uop_valid,
    output logic                uop_ready,
    output um32_pkg::out_item_t out_item,
    output logic                out_valid,
    input  logic                out_ready
);
    localparam int IdxW = $clog2(REGISTER_COUNT);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [31:0] rf_reg [REGISTER_COUNT];
    logic        stopped_reg, stopped_next;
    logic [1:0]  state_reg, state_next;
    logic [IdxW-1:0] dst_reg;
    logic [31:0] mul_reg;
    um32_pkg::out_item_t res_reg, res_next;
    logic        ov_reg, ov_next;
    logic        wr_en;
    logic [IdxW-1:0] wr_idx;
    logic [31:0] wr_val;
    logic [31:0] vb, vc;
    logic        can_emit;
    logic        div_start, div_done;
    logic [31:0] div_q;

    assign vb       = rf_reg[uop.rb[IdxW-1:0]];
    assign vc       = rf_reg[uop.rc[IdxW-1:0]];
    assign can_emit = !ov_reg || out_ready;
    assign out_item = res_reg;
    assign out_valid = ov_reg;
    assign uop_ready = (state_reg == S_IDLE) && can_emit;

    um32_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (vb),
        .divisor  (vc),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next   = state_reg;
        stopped_next = stopped_reg;
        res_next     = res_reg;
        ov_next      = ov_reg && !out_ready;
        wr_en        = 1'b0;
        wr_idx       = uop.ra[IdxW-1:0];
        wr_val       = '0;
        div_start    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (uop_valid && can_emit)
                begin
                    res_next = '{status: um32_pkg::ST_DONE, out_byte: 8'd0,
                                 written_value: 32'd0};
                    ov_next  = 1'b1;
                    if (stopped_reg)
                    begin
                        res_next.status = um32_pkg::ST_HALT;
                    end
                    else
                    begin
                        case (uop.op)
                            um32_pkg::OP_CMOV:
                            begin
                                if (vc != 32'd0)
                                begin
                                    wr_en = 1'b1;
                                    wr_val = vb;
                                end
                            end
                            um32_pkg::OP_ADD:
                            begin
                                wr_en  = 1'b1;
                                wr_val = vb + vc;
                            end
                            um32_pkg::OP_MUL:
                            begin
                                ov_next    = 1'b0;
                                state_next = S_MUL;
                            end
                            um32_pkg::OP_DIV:
                            begin
                                if (vc == 32'd0)
                                begin
                                    res_next.status = um32_pkg::ST_FAULT;
                                    stopped_next    = 1'b1;
                                end
                                else
                                begin
                                    ov_next    = 1'b0;
                                    div_start  = 1'b1;
                                    state_next = S_DIV;
                                end
                            end
                            um32_pkg::OP_NAND:
                            begin
                                wr_en  = 1'b1;
                                wr_val = ~(vb & vc);
                            end
                            um32_pkg::OP_HALT:
                            begin
                                res_next.status = um32_pkg::ST_HALT;
                                stopped_next    = 1'b1;
                            end
                            um32_pkg::OP_OUT:
                            begin
                                if (vc > 32'd255)
                                begin
                                    res_next.status = um32_pkg::ST_FAULT;
                                    stopped_next    = 1'b1;
                                end
                                else
                                begin
                                    res_next.status   = um32_pkg::ST_EMIT;
                                    res_next.out_byte = vc[7:0];
                                end
                            end
                            um32_pkg::OP_IN:
                            begin
                                wr_en  = 1'b1;
                                wr_idx = uop.rc[IdxW-1:0];
                                wr_val = uop.eof ? 32'hFFFF_FFFF : {24'd0, uop.byte_in};
                            end
                            um32_pkg::OP_LDV:
                            begin
                                wr_en  = 1'b1;
                                wr_idx = uop.rl[IdxW-1:0];
                                wr_val = {7'd0, uop.imm};
                            end
                            um32_pkg::OP_SLOAD, um32_pkg::OP_SSTOR, um32_pkg::OP_MAP,
                            um32_pkg::OP_UNMAP, um32_pkg::OP_LDPRG:
                            begin
                                res_next.status = um32_pkg::ST_UNSUP;
                            end
                            default:
                            begin
                                res_next.status = um32_pkg::ST_FAULT;
                                stopped_next    = 1'b1;
                            end
                        endcase
                        res_next.written_value = wr_val;
                    end
                end
            end
            S_MUL:
            begin
                wr_en      = 1'b1;
                wr_idx     = dst_reg;
                wr_val     = mul_reg;
                res_next   = '{status: um32_pkg::ST_DONE, out_byte: 8'd0,
                               written_value: mul_reg};
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    wr_en      = 1'b1;
                    wr_idx     = dst_reg;
                    wr_val     = div_q;
                    res_next   = '{status: um32_pkg::ST_DONE, out_byte: 8'd0,
                                   written_value: div_q};
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (state_reg == S_IDLE)
        begin
            dst_reg <= uop.ra[IdxW-1:0];
            mul_reg <= vb * vc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
            stopped_reg <= 1'b0;
            state_reg   <= S_IDLE;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                rf_reg[wr_idx] <= wr_val;
            end
            stopped_reg <= stopped_next;
            state_reg   <= state_next;
            ov_reg      <= ov_next;
        end
    end
endmodule

// ===== rtl/core/um32_register_execute_unit.sv =====
// Top level of the UM32 register execute unit.
//
// Usage:
//   in channel  (in_valid/in_ready, in_item): one instruction word with the
//   byte and end-of-input flag an input instruction would consume.
//   out channel (out_valid/out_ready, out_item): one result per instruction,
//   in order: status, emitted byte and the value written to a register.
// Flow: a two-entry decode queue feeds the execute sequencer. A simple op
//   registers its result straight from the idle state; a multiply passes
//   through the S_MUL state and a divide waits in S_DIV for the radix-2
//   divider, which retires one quotient bit per cycle. A new instruction is
//   taken only in the idle state and while the output register can be freed.
// Reset: all registers read zero, the unit runs, queue and output are empty.
// Stall: when out_ready is low the result holds in the output register, the
//   execute stage stops, and the queue fills and then drops in_ready.
// Halt or fault stops the unit: later instructions report halted until reset.
module um32_register_execute_unit #(
    parameter int REGISTER_COUNT = um32_pkg::RegCount
) (
    input  logic                clk,
    input  logic                rst_n,
    input  um32_pkg::in_item_t  in_item,
    input  logic                in_valid,
    output logic                in_ready,
    output um32_pkg::out_item_t out_item,
    output logic                out_valid,
    input  logic                out_ready
);
    um32_pkg::uop_t uop;
    logic           uop_valid;
    logic           uop_ready;

    // Decode and queue the transfer.
    um32_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .uop       (uop),
        .uop_valid (uop_valid),
        .uop_ready (uop_ready)
    );

    // Execute against the register file and hold the result.
    um32_back #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .uop       (uop),
        .uop_valid (uop_valid),
        .uop_ready (uop_ready),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );
endmodule

// ===== rtl/core/um32_checker.sv =====
// Port-level checker for the UM32 execute unit, bound to the top level.
`include "um32_register_execute_unit_assert.svh"
module um32_checker (
    input logic                clk,
    input logic                rst_n,
    input um32_pkg::out_item_t out_item,
    input logic                out_valid,
    input logic                out_ready
);
    `UM32_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_item), "result changed while stalled")
    `UM32_ASSERT_NOW(a_status_range, clk, rst_n, out_valid,
        out_item.status <= um32_pkg::ST_UNSUP, "status code out of range")
    `UM32_ASSERT_NOW(a_byte_only_emit, clk, rst_n,
        out_valid && out_item.status != um32_pkg::ST_EMIT,
        out_item.out_byte == 8'd0, "byte without emit")
    `UM32_ASSERT_NEXT(a_halt_sticky, clk, rst_n,
        out_valid && out_ready && out_item.status == um32_pkg::ST_HALT,
        !out_valid || out_item.status == um32_pkg::ST_HALT, "ran after halt")
endmodule

bind um32_register_execute_unit um32_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ready)
);
